// ===== design/number_to_ascii_digit_formatter_unit_macros.svh =====
// assertion macros shared by the formatter checker
`ifndef NUMBER_TO_ASCII_DIGIT_FORMATTER_UNIT_MACROS_SVH
`define NUMBER_TO_ASCII_DIGIT_FORMATTER_UNIT_MACROS_SVH

// clocked assertion, held off while reset is high
`define NFC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define NFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/nfc_pkg.sv =====
// shared constants, types and helper functions of the number to ascii formatter
package nfc_pkg;

   localparam int MAX_DIGITS     = 32;
   localparam int SCREEN_LINES   = 4;
   localparam int SCREEN_COLUMNS = 16;
   localparam int NUMBER_WIDTH   = 32;
   localparam int DIGIT_WIDTH    = 4;
   localparam int IDX_WIDTH      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_WIDTH      = $clog2(MAX_DIGITS + 1);
   localparam int STEP_WIDTH     = $clog2(NUMBER_WIDTH);

   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_A     = 7'h41;
   localparam logic [6:0] ASCII_PLUS  = 7'h2B;
   localparam logic [6:0] ASCII_MINUS = 7'h2D;

   localparam logic [DIGIT_WIDTH-1:0] DEC_BASE   = DIGIT_WIDTH'(10);
   localparam logic [DIGIT_WIDTH-1:0] DEC_LIMIT  = DIGIT_WIDTH'(5);
   localparam logic [DIGIT_WIDTH-1:0] DEC_ADJUST = DIGIT_WIDTH'(3);

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_BIN
   } radix_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_CONVERT,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      radix_type   radix;
   } cell_ctrl_type;

   function automatic logic [6:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [6:0] code;
      if (d < DEC_BASE) begin
         code = ASCII_ZERO + 7'(d);
      end else begin
         code = ASCII_A + 7'(d - DEC_BASE);
      end
      return code;
   endfunction

   function automatic logic is_on_screen(input logic [7:0] line, input logic [7:0] column);
      return (line >= 8'd1) && (line <= 8'(SCREEN_LINES)) &&
             (column >= 8'd1) && (column <= 8'(SCREEN_COLUMNS));
   endfunction

endpackage

// ===== design/nfc_cell.sv =====
// one digit cell: clear, bit shift-in (with double-dabble adjust in decimal mode), or digit hand-over to the next cell
module nfc_cell (
   input  logic                             clock,
   input  nfc_pkg::cell_ctrl_type           ctrl,
   input  logic                             carry_in,
   input  logic [nfc_pkg::DIGIT_WIDTH-1:0]  neighbor_digit,
   output logic                             carry_out,
   output logic [nfc_pkg::DIGIT_WIDTH-1:0]  digit_out
);
   import nfc_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;
   logic [DIGIT_WIDTH-1:0] shifted;

   always_comb begin
      adjusted = (digit_ff >= DEC_LIMIT) ? (digit_ff + DEC_ADJUST) : digit_ff;
      case (ctrl.radix)
         RADIX_DEC: begin
            shifted   = {adjusted[DIGIT_WIDTH-2:0], carry_in};
            carry_out = adjusted[DIGIT_WIDTH-1];
         end
         RADIX_BIN: begin
            shifted   = {(DIGIT_WIDTH-1)'(0), carry_in};
            carry_out = digit_ff[0];
         end
         default: begin
            shifted   = {digit_ff[DIGIT_WIDTH-2:0], carry_in};
            carry_out = digit_ff[DIGIT_WIDTH-1];
         end
      endcase
      case (ctrl.op)
         OP_CLEAR:   digit_in = '0;
         OP_CONVERT: digit_in = shifted;
         OP_SHIFT:   digit_in = neighbor_digit;
         default:    digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff;

endmodule

// ===== design/nfc_chain.sv =====
// row of digit cells with the output tap
module nfc_chain (
   input  logic                             clock,
   input  nfc_pkg::cell_ctrl_type           ctrl,
   input  logic                             bit_in,
   input  logic [nfc_pkg::IDX_WIDTH-1:0]    tap_sel,
   output logic [nfc_pkg::DIGIT_WIDTH-1:0]  tap_digit
);
   import nfc_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit [MAX_DIGITS];
   logic                   carry [MAX_DIGITS];

   assign carry[0] = bit_in;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      logic [DIGIT_WIDTH-1:0] neighbor;
      if (i == 0) begin : g_first
         assign neighbor = '0;
      end else begin : g_rest
         assign neighbor = digit[i-1];
      end
      if (i < MAX_DIGITS - 1) begin : g_mid
         nfc_cell u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .carry_in       (carry[i]),
            .neighbor_digit (neighbor),
            .carry_out      (carry[i+1]),
            .digit_out      (digit[i])
         );
      end else begin : g_top
         nfc_cell u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .carry_in       (carry[i]),
            .neighbor_digit (neighbor),
            .carry_out      (),
            .digit_out      (digit[i])
         );
      end
   end

   assign tap_digit = digit[tap_sel];

endmodule

// ===== design/number_to_ascii_digit_formatter_unit.sv =====
// number to ascii formatter top level: sequencer, digit cell row and character output register
// the sign beat (signed mode) comes right after the request state; digit beats follow the conversion
// an item goes through the request, the sign state in signed mode, the conversion and one emit step per digit
// the conversion shifts the 32 number bits into the digit cell row one bit a cycle; a digit count of 0 skips it
// digit characters leave one per cycle from the row tap while the output is not stalled; the row shifts toward it
// synchronous reset clears the sequencer and output valid; digit cells are cleared per item
module number_to_ascii_digit_formatter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic [nfc_pkg::NUMBER_WIDTH-1:0]   req_number,
   input  logic [5:0]                         req_digit_count,
   input  logic [7:0]                         req_start_line,
   input  logic [7:0]                         req_start_column,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [6:0]                         rsp_ascii_code,
   output logic [7:0]                         rsp_char_line,
   output logic [7:0]                         rsp_char_column,
   output logic                               rsp_on_screen,
   output logic                               rsp_last_char
);
   import nfc_pkg::*;

   typedef enum logic [1:0] {
      CMD_UNSIGNED,
      CMD_SIGNED,
      CMD_HEX,
      CMD_BINARY
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic [NUMBER_WIDTH-1:0]   value_ff;
   radix_type                 radix_ff;
   logic [CNT_WIDTH-1:0]      cnt_ff;
   logic [CNT_WIDTH-1:0]      rem_ff;
   logic [STEP_WIDTH-1:0]     step_ff;
   logic [7:0]                line_ff;
   logic [7:0]                col_ff;
   logic                      neg_ff;

   logic                      rsp_valid_ff;
   logic [6:0]                rsp_ascii_code_ff;
   logic [7:0]                rsp_char_line_ff;
   logic [7:0]                rsp_char_column_ff;
   logic                      rsp_on_screen_ff;
   logic                      rsp_last_char_ff;

   logic                      req_fire;
   logic                      out_free;
   logic                      char_load;
   logic [CNT_WIDTH-1:0]      cnt_in;
   logic                      neg_in;
   radix_type                 radix_in;
   cell_ctrl_type             cell_ctrl;
   logic [IDX_WIDTH-1:0]      tap_sel;
   logic [DIGIT_WIDTH-1:0]    tap_digit;
   logic                      col_visible;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      req_fire  = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;
      char_load = out_free && ((state_ff == ST_SIGN) || (state_ff == ST_EMIT));
      cnt_in    = (req_digit_count > 6'(MAX_DIGITS)) ? CNT_WIDTH'(MAX_DIGITS)
                                                     : CNT_WIDTH'(req_digit_count);
      neg_in    = (req_command == CMD_SIGNED) && req_number[NUMBER_WIDTH-1];
      case (req_command)
         CMD_HEX:    radix_in = RADIX_HEX;
         CMD_BINARY: radix_in = RADIX_BIN;
         default:    radix_in = RADIX_DEC;
      endcase
      cell_ctrl.radix = radix_ff;
      cell_ctrl.op    = OP_HOLD;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) cell_ctrl.op = OP_CLEAR;
         ST_CONVERT: cell_ctrl.op = OP_CONVERT;
         ST_EMIT:    if (out_free) cell_ctrl.op = OP_SHIFT;
         default:    cell_ctrl.op = OP_HOLD;
      endcase
      tap_sel     = IDX_WIDTH'(cnt_ff - CNT_WIDTH'(1));
      col_visible = is_on_screen(line_ff, col_ff);
   end

   nfc_chain u_chain (
      .clock     (clock),
      .ctrl      (cell_ctrl),
      .bit_in    (value_ff[NUMBER_WIDTH-1]),
      .tap_sel   (tap_sel),
      .tap_digit (tap_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !char_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  value_ff <= neg_in ? (~req_number + NUMBER_WIDTH'(1)) : req_number;
                  radix_ff <= radix_in;
                  cnt_ff   <= cnt_in;
                  rem_ff   <= cnt_in;
                  step_ff  <= '0;
                  line_ff  <= req_start_line;
                  col_ff   <= req_start_column;
                  neg_ff   <= neg_in;
                  if (req_command == CMD_SIGNED) begin
                     state_ff <= ST_SIGN;
                  end else if (cnt_in == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_CONVERT;
                  end
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ascii_code_ff  <= neg_ff ? ASCII_MINUS : ASCII_PLUS;
                  rsp_char_line_ff   <= line_ff;
                  rsp_char_column_ff <= col_ff;
                  rsp_on_screen_ff   <= col_visible;
                  rsp_last_char_ff   <= (cnt_ff == '0);
                  col_ff             <= col_ff + 8'd1;
                  state_ff           <= (cnt_ff == '0) ? ST_IDLE : ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               value_ff <= {value_ff[NUMBER_WIDTH-2:0], 1'b0};
               step_ff  <= step_ff + STEP_WIDTH'(1);
               if (step_ff == STEP_WIDTH'(NUMBER_WIDTH - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ascii_code_ff  <= digit_to_ascii(tap_digit);
                  rsp_char_line_ff   <= line_ff;
                  rsp_char_column_ff <= col_ff;
                  rsp_on_screen_ff   <= col_visible;
                  rsp_last_char_ff   <= (rem_ff == CNT_WIDTH'(1));
                  col_ff             <= col_ff + 8'd1;
                  rem_ff             <= rem_ff - CNT_WIDTH'(1);
                  if (rem_ff == CNT_WIDTH'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ascii_code  = rsp_ascii_code_ff;
   assign rsp_char_line   = rsp_char_line_ff;
   assign rsp_char_column = rsp_char_column_ff;
   assign rsp_on_screen   = rsp_on_screen_ff;
   assign rsp_last_char   = rsp_last_char_ff;

endmodule

// ===== design/nfc_checker.sv =====
// port-level checker for the formatter and its bind to the top level
`include "number_to_ascii_digit_formatter_unit_macros.svh"

module nfc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [1:0]                         req_command,
   input logic [nfc_pkg::NUMBER_WIDTH-1:0]   req_number,
   input logic [5:0]                         req_digit_count,
   input logic [7:0]                         req_start_line,
   input logic [7:0]                         req_start_column,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [6:0]                         rsp_ascii_code,
   input logic [7:0]                         rsp_char_line,
   input logic [7:0]                         rsp_char_column,
   input logic                               rsp_on_screen,
   input logic                               rsp_last_char
);

   `NFC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ascii_code) && $stable(rsp_char_column) && $stable(rsp_last_char), "result beat changed while stalled")

   `NFC_ASSERT(a_busy_mid_string, clock, reset, rsp_valid && !rsp_last_char |-> !req_ready, "request taken before the string ended")

   `NFC_ASSERT(a_column_step, clock, reset, (rsp_valid && rsp_ready && !rsp_last_char) ##1 rsp_valid |-> (rsp_char_column == $past(rsp_char_column) + 8'd1) && (rsp_char_line == $past(rsp_char_line)), "next character not one column on")

   `NFC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind number_to_ascii_digit_formatter_unit nfc_checker u_nfc_checker (.*);

// ===== sim/formatter_tb_pkg.sv =====
// format command codes shared by the formatter testbench files
`timescale 1ns / 1ps

package formatter_tb_pkg;

   typedef enum logic [1:0] {
      FMT_UDEC = 2'd0,
      FMT_SDEC = 2'd1,
      FMT_HEX  = 2'd2,
      FMT_BIN  = 2'd3
   } format_cmd_type;

endpackage

// ===== sim/number_to_ascii_digit_formatter_unit_checker.sv =====
// formatter checker: predicts the character beats of each request and compares them
`timescale 1ns / 1ps

module number_to_ascii_digit_formatter_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_number,
   input  logic [5:0]  req_digit_count,
   input  logic [7:0]  req_start_line,
   input  logic [7:0]  req_start_column,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [6:0]  rsp_ascii_code,
   input  logic [7:0]  rsp_char_line,
   input  logic [7:0]  rsp_char_column,
   input  logic        rsp_on_screen,
   input  logic        rsp_last_char,
   output int          failures,
   output int          pending_chars,
   output int          requests_seen,
   output int          chars_checked
);
   import nfc_pkg::*;
   import formatter_tb_pkg::*;

   typedef struct {
      logic [6:0] ascii;
      logic [7:0] line;
      logic [7:0] column;
      logic       visible;
      logic       last;
   } glyph_type;

   glyph_type expected_glyphs[$];

   function automatic logic [3:0] digit_of(format_cmd_type fmt, logic [31:0] value, int pos);
      logic [31:0] v;
      v = value;
      if (fmt == FMT_HEX) begin
         return (pos < 8) ? 4'((v >> (4 * pos)) & 32'hF) : 4'd0;
      end
      if (fmt == FMT_BIN) begin
         return (pos < 32) ? 4'((v >> pos) & 32'h1) : 4'd0;
      end
      if (pos >= 10) begin
         return 4'd0;
      end
      for (int i = 0; i < pos; i++) begin
         v = v / 32'd10;
      end
      return 4'(v % 32'd10);
   endfunction

   function automatic void push_glyph(logic [6:0] ascii, logic [7:0] line,
                                      logic [7:0] column, logic last);
      glyph_type g;
      g.ascii   = ascii;
      g.line    = line;
      g.column  = column;
      g.visible = (line >= 8'd1) && (line <= 8'(SCREEN_LINES)) &&
                  (column >= 8'd1) && (column <= 8'(SCREEN_COLUMNS));
      g.last    = last;
      expected_glyphs.push_back(g);
   endfunction

   function automatic void format_number(format_cmd_type fmt, logic [31:0] number,
                                         logic [5:0] count_in, logic [7:0] line,
                                         logic [7:0] column);
      int          count;
      logic [31:0] magnitude;
      logic [7:0]  col;
      logic [3:0]  d;
      count     = (int'(count_in) > MAX_DIGITS) ? MAX_DIGITS : int'(count_in);
      magnitude = number;
      col       = column;
      if (fmt == FMT_SDEC) begin
         if (number[31]) begin
            magnitude = ~number + 32'd1;
         end
         push_glyph(number[31] ? ASCII_MINUS : ASCII_PLUS, line, col, count == 0);
         col = col + 8'd1;
      end
      for (int i = 0; i < count; i++) begin
         d = digit_of(fmt, magnitude, count - 1 - i);
         push_glyph((d < 4'd10) ? 7'(ASCII_ZERO + 7'(d)) : 7'(ASCII_A + 7'(d) - 7'd10),
                    line, col + 8'(i), i + 1 == count);
      end
   endfunction

   always @(posedge clock) begin
      glyph_type g;
      int        errs;
      errs = 0;
      if (reset) begin
         expected_glyphs.delete();
         failures      <= 0;
         requests_seen <= 0;
         chars_checked <= 0;
      end else begin
         if (req_valid && req_ready) begin
            format_number(format_cmd_type'(req_command), req_number, req_digit_count,
                          req_start_line, req_start_column);
            requests_seen <= requests_seen + 1;
         end
         if (rsp_valid && rsp_ready) begin
            chars_checked <= chars_checked + 1;
            if (expected_glyphs.size() == 0) begin
               $error("unexpected character beat: code %0h line %0d column %0d",
                      rsp_ascii_code, rsp_char_line, rsp_char_column);
               errs++;
            end else begin
               g = expected_glyphs.pop_front();
               if (rsp_ascii_code !== g.ascii) begin
                  $error("ascii_code: expected %0h actual %0h", g.ascii, rsp_ascii_code);
                  errs++;
               end
               if (rsp_char_line !== g.line) begin
                  $error("char_line: expected %0d actual %0d", g.line, rsp_char_line);
                  errs++;
               end
               if (rsp_char_column !== g.column) begin
                  $error("char_column: expected %0d actual %0d", g.column, rsp_char_column);
                  errs++;
               end
               if (rsp_on_screen !== g.visible) begin
                  $error("on_screen: expected %0b actual %0b", g.visible, rsp_on_screen);
                  errs++;
               end
               if (rsp_last_char !== g.last) begin
                  $error("last_char: expected %0b actual %0b", g.last, rsp_last_char);
                  errs++;
               end
            end
         end
         if (errs != 0) begin
            failures <= failures + errs;
         end
      end
      pending_chars <= expected_glyphs.size();
   end

endmodule

// ===== sim/number_to_ascii_digit_formatter_unit_tb.sv =====
// formatter testbench top: clock, reset, request and response stimulus, verdict
`timescale 1ns / 1ps

module number_to_ascii_digit_formatter_unit_tb;
   import nfc_pkg::*;
   import formatter_tb_pkg::*;

   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [31:0] req_number;
   logic [5:0]  req_digit_count;
   logic [7:0]  req_start_line;
   logic [7:0]  req_start_column;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_ascii_code;
   logic [7:0]  rsp_char_line;
   logic [7:0]  rsp_char_column;
   logic        rsp_on_screen;
   logic        rsp_last_char;

   int failures;
   int pending_chars;
   int requests_seen;
   int chars_checked;

   logic calm;
   logic hold_rsp;

   number_to_ascii_digit_formatter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_number       (req_number),
      .req_digit_count  (req_digit_count),
      .req_start_line   (req_start_line),
      .req_start_column (req_start_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ascii_code   (rsp_ascii_code),
      .rsp_char_line    (rsp_char_line),
      .rsp_char_column  (rsp_char_column),
      .rsp_on_screen    (rsp_on_screen),
      .rsp_last_char    (rsp_last_char)
   );

   number_to_ascii_digit_formatter_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_number       (req_number),
      .req_digit_count  (req_digit_count),
      .req_start_line   (req_start_line),
      .req_start_column (req_start_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ascii_code   (rsp_ascii_code),
      .rsp_char_line    (rsp_char_line),
      .rsp_char_column  (rsp_char_column),
      .rsp_on_screen    (rsp_on_screen),
      .rsp_last_char    (rsp_last_char),
      .failures         (failures),
      .pending_chars    (pending_chars),
      .requests_seen    (requests_seen),
      .chars_checked    (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // returns at a falling edge with valid still high; only a random gap drops it
   task automatic send_request(format_cmd_type cmd, logic [31:0] number, logic [5:0] count,
                               logic [7:0] line, logic [7:0] column);
      if (!calm && $urandom_range(0, 99) < 23) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_command      = cmd;
      req_number       = number;
      req_digit_count  = count;
      req_start_line   = line;
      req_start_column = column;
      req_valid        = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random();
      int          r;
      logic [31:0] number;
      logic [5:0]  count;
      logic [7:0]  line;
      logic [7:0]  column;
      r = $urandom_range(0, 99);
      if (r < 50)      number = $urandom;
      else if (r < 70) number = $urandom_range(0, 999);
      else if (r < 85) number = -$urandom_range(1, 1000);
      else begin
         case ($urandom_range(0, 3))
            0: number = 32'h8000_0000;
            1: number = 32'h7FFF_FFFF;
            2: number = 32'hFFFF_FFFF;
            default: number = 32'd0;
         endcase
      end
      r = $urandom_range(0, 99);
      if (r < 70)      count = 6'($urandom_range(0, 12));
      else if (r < 95) count = 6'($urandom_range(13, 33));
      else             count = 6'($urandom_range(34, 63));
      line   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 5))
                                            : 8'($urandom_range(0, 255));
      column = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 20))
                                            : 8'($urandom_range(0, 255));
      send_request(format_cmd_type'($urandom_range(0, 3)), number, count, line, column);
   endtask

   // response side: random backpressure, calm stretch, and one long hold
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (calm) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= 23);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = FMT_UDEC;
      req_number       = '0;
      req_digit_count  = '0;
      req_start_line   = '0;
      req_start_column = '0;
      calm             = 1'b0;
      hold_rsp         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(FMT_UDEC, 32'd0,          6'd1,  8'd1,   8'd1);
      send_request(FMT_UDEC, 32'hFFFF_FFFF,  6'd10, 8'd1,   8'd1);
      send_request(FMT_UDEC, 32'hFFFF_FFFF,  6'd12, 8'd4,   8'd16);
      send_request(FMT_UDEC, 32'd12345,      6'd0,  8'd2,   8'd2);
      send_request(FMT_SDEC, 32'h8000_0000,  6'd10, 8'd2,   8'd3);
      send_request(FMT_SDEC, 32'h7FFF_FFFF,  6'd11, 8'd3,   8'd0);
      send_request(FMT_SDEC, 32'hFFFF_FFFF,  6'd1,  8'd4,   8'd15);
      send_request(FMT_SDEC, 32'd0,          6'd0,  8'd1,   8'd16);
      send_request(FMT_SDEC, 32'h8000_0000,  6'd0,  8'd5,   8'd17);
      send_request(FMT_HEX,  32'hDEAD_BEEF,  6'd8,  8'd1,   8'd9);
      send_request(FMT_HEX,  32'hFFFF_FFFF,  6'd9,  8'd2,   8'd8);
      send_request(FMT_HEX,  32'd0,          6'd0,  8'd3,   8'd1);
      send_request(FMT_HEX,  32'h0123_ABCD,  6'd32, 8'd0,   8'd0);
      send_request(FMT_BIN,  32'hFFFF_FFFF,  6'd32, 8'd5,   8'd17);
      send_request(FMT_BIN,  32'hAAAA_AAAA,  6'd33, 8'd255, 8'd255);
      send_request(FMT_BIN,  32'h5555_5555,  6'd63, 8'd3,   8'd240);
      send_request(FMT_UDEC, 32'd1000000000, 6'd63, 8'd4,   8'd250);
      send_request(FMT_SDEC, 32'd1,          6'd32, 8'd1,   8'd255);
      send_request(FMT_BIN,  32'd0,          6'd0,  8'd2,   8'd4);
      send_request(FMT_HEX,  32'h89AB_CDEF,  6'd1,  8'd3,   8'd16);
      send_request(FMT_UDEC, 32'hFFFF_FFFF,  6'd33, 8'd255, 8'd0);

      repeat (38) send_random();

      // output held off while requests keep coming, so the input side stalls
      hold_rsp = 1'b1;
      send_request(FMT_BIN,  $urandom, 6'd32, 8'd1, 8'd1);
      send_request(FMT_SDEC, $urandom, 6'd20, 8'd2, 8'd0);
      send_request(FMT_HEX,  $urandom, 6'd8,  8'd3, 8'd5);
      repeat (3) send_random();

      req_valid = 1'b0;
      wait (pending_chars == 0);
      @(negedge clock);

      calm = 1'b1;
      repeat (30) send_random();
      calm = 1'b0;

      repeat (38) send_random();

      req_valid = 1'b0;
      wait (pending_chars == 0);
      repeat (80) @(negedge clock);

      $display("%0d requests in all four formats checked, %0d character beats compared",
               requests_seen, chars_checked);
      $display("included zero and saturated counts, extreme values, off-screen positions");
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
